// ----- design/sfr_pkg.sv -----
// ----------------------------------------------------------------------------
// sfr_pkg - shared types and constants of the STX/ETX frame receiver
// Reply codes, word layout of a pending reply and the reply frame table.
// ----------------------------------------------------------------------------
package sfr_pkg;

	localparam int CHUNK_DEPTH = 256;
	localparam int BYTE_W      = 8;
	localparam int LEN_W       = 9;
	localparam int KIND_W      = 2;
	localparam int STEP_W      = 4;
	localparam int HDR_LEN     = 3;

	localparam logic [BYTE_W-1:0] SOF_BYTE   = 8'h02;
	localparam logic [BYTE_W-1:0] EOF_BYTE   = 8'h03;
	localparam logic [BYTE_W-1:0] REPLY_TYPE = 8'h06;
	localparam logic [BYTE_W-1:0] DBG_TYPE   = 8'h00;
	localparam logic [BYTE_W-1:0] ACK_LEN    = 8'h01;
	localparam logic [BYTE_W-1:0] DBG_LEN    = 8'h05;
	localparam logic [BYTE_W-1:0] CHR_ACK    = 8'h41;	// 'A'
	localparam logic [BYTE_W-1:0] CHR_NACK   = 8'h4E;	// 'N'
	localparam logic [BYTE_W-1:0] CHR_E      = 8'h65;	// 'e'
	localparam logic [BYTE_W-1:0] CHR_R      = 8'h72;	// 'r'
	localparam logic [BYTE_W-1:0] CHR_O      = 8'h6F;	// 'o'

	localparam logic [KIND_W-1:0] KIND_TX   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_GOOD = 2'd1;
	localparam logic [KIND_W-1:0] KIND_BAD  = 2'd2;
	localparam logic [KIND_W-1:0] KIND_READ = 2'd3;

	typedef enum logic [1:0] {
		OP_READ,
		OP_GOOD,
		OP_BAD
	} op_t;

	// one pending reply handed from the chunk logic to the sequencer
	typedef struct packed {
		op_t               op;
		logic [BYTE_W-1:0] ftype;
		logic [LEN_W-1:0]  flen;
	} job_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [BYTE_W-1:0] data;
		logic              last;
	} reply_t;

	function automatic reply_t tx_word(input logic [BYTE_W-1:0] b, input logic is_last);
		reply_t r;
		r.kind = KIND_TX;
		r.data = b;
		r.last = is_last;
		return r;
	endfunction

	// word table of the replies; step 0 is the status word of a chunk reply, or the only word of a read
	function automatic reply_t reply_rom(input op_t op, input logic [STEP_W-1:0] step);
		reply_t r;
		r = '{kind: KIND_TX, data: '0, last: 1'b0};
		unique case (op)
			OP_READ: r = '{kind: KIND_READ, data: '0, last: 1'b1};
			OP_GOOD: begin
				unique case (step)
					4'd0: r = '{kind: KIND_GOOD, data: '0, last: 1'b0};
					4'd1: r = tx_word(SOF_BYTE, 1'b0);
					4'd2: r = tx_word(REPLY_TYPE, 1'b0);
					4'd3: r = tx_word(ACK_LEN, 1'b0);
					4'd4: r = tx_word(CHR_ACK, 1'b0);
					4'd5: r = tx_word(EOF_BYTE, 1'b1);
					default: r = tx_word('0, 1'b1);
				endcase
			end
			OP_BAD: begin
				unique case (step)
					4'd0:  r = '{kind: KIND_BAD, data: '0, last: 1'b0};
					4'd1:  r = tx_word(SOF_BYTE, 1'b0);
					4'd2:  r = tx_word(DBG_TYPE, 1'b0);
					4'd3:  r = tx_word(DBG_LEN, 1'b0);
					4'd4:  r = tx_word(CHR_E, 1'b0);
					4'd5:  r = tx_word(CHR_R, 1'b0);
					4'd6:  r = tx_word(CHR_R, 1'b0);
					4'd7:  r = tx_word(CHR_O, 1'b0);
					4'd8:  r = tx_word(CHR_R, 1'b0);
					4'd9:  r = tx_word(EOF_BYTE, 1'b0);
					4'd10: r = tx_word(SOF_BYTE, 1'b0);
					4'd11: r = tx_word(REPLY_TYPE, 1'b0);
					4'd12: r = tx_word(ACK_LEN, 1'b0);
					4'd13: r = tx_word(CHR_NACK, 1'b0);
					4'd14: r = tx_word(EOF_BYTE, 1'b1);
					default: r = tx_word('0, 1'b1);
				endcase
			end
			default: r = tx_word('0, 1'b1);
		endcase
		return r;
	endfunction

endpackage

// ----- design/sfr_reply_seq.sv -----
// ----------------------------------------------------------------------------
// sfr_reply_seq - reply word sequencer
// Holds one pending reply and steps it out one word per cycle while res_ready is high.
// ----------------------------------------------------------------------------
module sfr_reply_seq (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                job_valid,
	input  sfr_pkg::job_t                       job,
	output logic                                job_ready,
	input  logic [sfr_pkg::BYTE_W-1:0]          rd_data,
	output logic                                res_valid,
	input  logic                                res_ready,
	output logic [sfr_pkg::KIND_W-1:0]          kind,
	output logic [sfr_pkg::BYTE_W-1:0]          data,
	output logic [sfr_pkg::BYTE_W-1:0]          frame_type,
	output logic [sfr_pkg::LEN_W-1:0]           frame_length,
	output logic                                last
);

	logic                        busy_q;
	logic [sfr_pkg::STEP_W-1:0]  step_q;
	sfr_pkg::job_t               job_s1;
	sfr_pkg::reply_t             word;
	logic                        first;

	assign word      = sfr_pkg::reply_rom(job_s1.op, step_q);
	assign first     = (step_q == '0);
	assign job_ready = !busy_q || (res_ready && word.last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (job_ready) begin
			busy_q <= job_valid;
			step_q <= '0;
		end else if (res_ready) begin
			step_q <= step_q + sfr_pkg::STEP_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (job_ready && job_valid) begin
			job_s1 <= job;
		end
	end

	assign res_valid    = busy_q;
	assign kind         = word.kind;
	assign data         = (job_s1.op == sfr_pkg::OP_READ) ? rd_data : word.data;
	assign frame_type   = (job_s1.op == sfr_pkg::OP_GOOD && first) ? job_s1.ftype : '0;
	assign frame_length = (job_s1.op != sfr_pkg::OP_READ && first) ? job_s1.flen : '0;
	assign last         = word.last;

endmodule

// ----- design/stx_etx_frame_receiver_ack_top.sv -----
// ----------------------------------------------------------------------------
// stx_etx_frame_receiver_ack_top - STX/ETX chunk receiver with ACK/NACK reply
// Gathers received bytes into chunks, decodes headers and answers each data
// chunk with a status word and the ACK frame, or the debug and NACK frames.
// ----------------------------------------------------------------------------
// The first result word is valid in the cycle after the input word is taken in.
// Throughput: one input word per cycle while no reply is pending; a reply goes
//   out one word per cycle while res_ready is high (1 for a read, 6 for a good
//   chunk, 15 for a bad one) and the next input is taken as its last word leaves.
// Read data comes from the chunk buffer's single registered read port.
// Reset: expected length 3, count and type cleared; buffer is not cleared.
// ----------------------------------------------------------------------------
module stx_etx_frame_receiver_ack_top #(
	parameter int CHUNK_DEPTH = sfr_pkg::CHUNK_DEPTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	output logic                          item_ready,
	input  logic                          action,
	input  logic [sfr_pkg::BYTE_W-1:0]    rx_byte,
	input  logic [sfr_pkg::BYTE_W-1:0]    read_index,
	output logic                          res_valid,
	input  logic                          res_ready,
	output logic [sfr_pkg::KIND_W-1:0]    kind,
	output logic [sfr_pkg::BYTE_W-1:0]    data,
	output logic [sfr_pkg::BYTE_W-1:0]    frame_type,
	output logic [sfr_pkg::LEN_W-1:0]     frame_length,
	output logic                          last
);

	localparam int AW  = $clog2(CHUNK_DEPTH);
	localparam int LW  = sfr_pkg::LEN_W;

	// chunk buffer: one write port (received bytes), one read port (reads)
	logic [sfr_pkg::BYTE_W-1:0] mem [CHUNK_DEPTH];
	logic [sfr_pkg::BYTE_W-1:0] rd_q;
	logic                       rd_in_range_q;

	// chunk state
	logic [LW-1:0]              expected_q;
	logic [LW-1:0]              count_q;
	logic [sfr_pkg::BYTE_W-1:0] msg_type_q;
	logic [sfr_pkg::BYTE_W-1:0] byte0_q;	// copies of the first two chunk
	logic [sfr_pkg::BYTE_W-1:0] byte1_q;	// bytes for header decode

	logic          acc;
	logic          rx_acc;
	logic          rd_acc;
	logic [LW-1:0] cnt_next;
	logic          chunk_done;
	logic          is_header;
	logic [LW-1:0] hdr_len;
	logic          rd_in_range;

	sfr_pkg::job_t job;
	logic          job_valid;
	logic          job_ready;

	assign item_ready = job_ready;
	assign acc        = item_valid && item_ready;
	assign rx_acc     = acc && !action;
	assign rd_acc     = acc && action;

	assign cnt_next   = count_q + LW'(1);
	assign chunk_done = (cnt_next == expected_q);
	// count_q is 2 at the end of a three-byte chunk, so both copies are held
	assign is_header  = (expected_q == LW'(sfr_pkg::HDR_LEN)) && (byte0_q == sfr_pkg::SOF_BYTE);
	assign hdr_len    = LW'(rx_byte) + LW'(1);
	assign rd_in_range = (LW'(read_index) < LW'(CHUNK_DEPTH));

	// a reply is due for every read and every completed data chunk
	always_comb begin
		job.op    = sfr_pkg::OP_READ;
		job.ftype = msg_type_q;
		job.flen  = expected_q;
		if (!action) begin
			// the last chunk byte is the one arriving now
			job.op = (rx_byte == sfr_pkg::EOF_BYTE) ? sfr_pkg::OP_GOOD : sfr_pkg::OP_BAD;
		end
	end

	assign job_valid = rd_acc || (rx_acc && chunk_done && !is_header);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_q <= LW'(sfr_pkg::HDR_LEN);
			count_q    <= '0;
			msg_type_q <= '0;
		end else if (rx_acc) begin
			if (!chunk_done) begin
				count_q <= cnt_next;
			end else begin
				count_q <= '0;
				if (is_header) begin
					msg_type_q <= byte1_q;
					// long headers saturate at the buffer depth
					expected_q <= (hdr_len > LW'(CHUNK_DEPTH)) ? LW'(CHUNK_DEPTH) : hdr_len;
				end else begin
					expected_q <= LW'(sfr_pkg::HDR_LEN);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rx_acc && count_q == LW'(0)) begin
			byte0_q <= rx_byte;
		end
		if (rx_acc && count_q == LW'(1)) begin
			byte1_q <= rx_byte;
		end
	end

	// count_q stays below expected_q, which never exceeds the depth
	always_ff @(posedge clk) begin
		if (rx_acc) begin
			mem[count_q[AW-1:0]] <= rx_byte;
		end
		if (rd_acc) begin
			rd_q          <= mem[read_index[AW-1:0]];
			rd_in_range_q <= rd_in_range;
		end
	end

	sfr_reply_seq u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.job_valid    (job_valid),
		.job          (job),
		.job_ready    (job_ready),
		.rd_data      (rd_in_range_q ? rd_q : '0),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.kind         (kind),
		.data         (data),
		.frame_type   (frame_type),
		.frame_length (frame_length),
		.last         (last)
	);

endmodule

// ----- tb/sv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench - self-checking bench for stx_etx_frame_receiver_ack_top
// Feeds received bytes and buffer reads through the word handshake, predicts
// every status, reply and read word in a bench-side model of the chunk logic
// and checks the result stream in order under random gaps on both sides.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TARGET_WORDS = 410;
	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int SETTLE_PAD   = 16;	// generous margin after the last result word

	typedef struct packed {
		logic [sfr_pkg::KIND_W-1:0] kind;
		logic [sfr_pkg::BYTE_W-1:0] data;
		logic [sfr_pkg::BYTE_W-1:0] ftype;
		logic [sfr_pkg::LEN_W-1:0]  flen;
		logic                       last;
	} reply_word_t;

	logic                         clk;
	logic                         arst_n;
	logic                         item_valid;
	logic                         item_ready;
	logic                         action;
	logic [sfr_pkg::BYTE_W-1:0]   rx_byte;
	logic [sfr_pkg::BYTE_W-1:0]   read_index;
	logic                         res_valid;
	logic                         res_ready;
	logic [sfr_pkg::KIND_W-1:0]   kind;
	logic [sfr_pkg::BYTE_W-1:0]   data;
	logic [sfr_pkg::BYTE_W-1:0]   frame_type;
	logic [sfr_pkg::LEN_W-1:0]    frame_length;
	logic                         last;

	// bench-side copy of the receiver state
	int unsigned                  chunk_len;
	int unsigned                  bytes_in_chunk;
	logic [sfr_pkg::BYTE_W-1:0]   latched_type;
	logic [sfr_pkg::BYTE_W-1:0]   chunk_mem [sfr_pkg::CHUNK_DEPTH];
	bit                           chunk_written [sfr_pkg::CHUNK_DEPTH];

	reply_word_t         reply_q [$];
	int                  fail_count;
	int                  words_sent;
	int                  cycle_count;
	bit                  no_gaps;	// shared by sender and receiver: no idling at all
	int                  hold_request;	// long receiver hold-off, picked up by the sink

	stx_etx_frame_receiver_ack_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.action       (action),
		.rx_byte      (rx_byte),
		.read_index   (read_index),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.kind         (kind),
		.data         (data),
		.frame_type   (frame_type),
		.frame_length (frame_length),
		.last         (last)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Expected reply words
	// ------------------------------------------------------------------
	function automatic void push_reply(input logic [sfr_pkg::KIND_W-1:0] k,
			input logic [sfr_pkg::BYTE_W-1:0] d, input logic [sfr_pkg::BYTE_W-1:0] t,
			input logic [sfr_pkg::LEN_W-1:0] n, input logic l);
		reply_word_t w;
		w.kind  = k;
		w.data  = d;
		w.ftype = t;
		w.flen  = n;
		w.last  = l;
		reply_q.push_back(w);
	endfunction

	// outgoing frame: SOF, type, length, payload, EOF
	function automatic void push_tx_frame(input logic [sfr_pkg::BYTE_W-1:0] ftype,
			input logic [sfr_pkg::BYTE_W-1:0] payload [$], input logic final_frame);
		logic [sfr_pkg::BYTE_W-1:0] words [$];
		words.push_back(sfr_pkg::SOF_BYTE);
		words.push_back(ftype);
		words.push_back(sfr_pkg::BYTE_W'(payload.size()));
		foreach (payload[i])
			words.push_back(payload[i]);
		words.push_back(sfr_pkg::EOF_BYTE);
		foreach (words[i])
			push_reply(sfr_pkg::KIND_TX, words[i], '0, '0,
				final_frame && (i == words.size() - 1));
	endfunction

	// works out the replies caused by one accepted word
	function automatic void predict_replies(input logic act, input logic [sfr_pkg::BYTE_W-1:0] b,
			input logic [sfr_pkg::BYTE_W-1:0] idx);
		int unsigned done_len;
		int unsigned next_len;
		if (act) begin
			push_reply(sfr_pkg::KIND_READ, chunk_mem[idx], '0, '0, 1'b1);
			return;
		end
		if (bytes_in_chunk < sfr_pkg::CHUNK_DEPTH) begin
			chunk_mem[bytes_in_chunk]     = b;
			chunk_written[bytes_in_chunk] = 1'b1;
		end
		bytes_in_chunk++;
		if (bytes_in_chunk < chunk_len)
			return;
		done_len       = chunk_len;
		bytes_in_chunk = 0;
		// a three-byte chunk opening with SOF is a header, even if meant as data
		if (done_len == sfr_pkg::HDR_LEN && chunk_mem[0] == sfr_pkg::SOF_BYTE) begin
			latched_type = chunk_mem[1];
			next_len     = int'(chunk_mem[2]) + 1;
			chunk_len    = (next_len > sfr_pkg::CHUNK_DEPTH) ? sfr_pkg::CHUNK_DEPTH : next_len;
			return;
		end
		chunk_len = sfr_pkg::HDR_LEN;
		if (chunk_mem[(done_len - 1) % sfr_pkg::CHUNK_DEPTH] == sfr_pkg::EOF_BYTE) begin
			push_reply(sfr_pkg::KIND_GOOD, '0, latched_type,
				sfr_pkg::LEN_W'(done_len), 1'b0);
			push_tx_frame(sfr_pkg::REPLY_TYPE, '{sfr_pkg::CHR_ACK}, 1'b1);
		end else begin
			push_reply(sfr_pkg::KIND_BAD, '0, '0, sfr_pkg::LEN_W'(done_len), 1'b0);
			push_tx_frame(sfr_pkg::DBG_TYPE, '{sfr_pkg::CHR_E, sfr_pkg::CHR_R,
				sfr_pkg::CHR_R, sfr_pkg::CHR_O, sfr_pkg::CHR_R}, 1'b0);
			push_tx_frame(sfr_pkg::REPLY_TYPE, '{sfr_pkg::CHR_NACK}, 1'b1);
		end
	endfunction

	// ------------------------------------------------------------------
	// Random helpers
	// ------------------------------------------------------------------
	// idle stretch: mostly short, now and then long
	function automatic int idle_len();
		return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 30);
	endfunction

	function automatic logic [sfr_pkg::BYTE_W-1:0] pick_byte();
		case ($urandom_range(0, 9))
			0: return 8'h00;
			1: return 8'hFF;
			2: return sfr_pkg::SOF_BYTE;
			3: return sfr_pkg::EOF_BYTE;
			default: return sfr_pkg::BYTE_W'($urandom_range(0, 255));
		endcase
	endfunction

	// only entries already written may be read back
	function automatic logic [sfr_pkg::BYTE_W-1:0] written_index();
		int idx;
		do idx = $urandom_range(0, sfr_pkg::CHUNK_DEPTH - 1);
		while (!chunk_written[idx]);
		return sfr_pkg::BYTE_W'(idx);
	endfunction

	function automatic int payload_len();
		return ($urandom_range(0, 9) < 8) ? $urandom_range(0, 6) : $urandom_range(7, 40);
	endfunction

	// ------------------------------------------------------------------
	// Word sender; called at the edge where the previous word was taken
	// ------------------------------------------------------------------
	task automatic send_word(input logic act, input logic [sfr_pkg::BYTE_W-1:0] b,
			input logic [sfr_pkg::BYTE_W-1:0] idx);
		int gap;
		gap = (no_gaps || $urandom_range(0, 9) < 6) ? 0 : idle_len();
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		action     <= act;
		rx_byte    <= b;
		read_index <= idx;
		@(posedge clk);
		while (!item_ready) @(posedge clk);
		predict_replies(act, b, idx);
		words_sent++;
	endtask

	task automatic send_rx(input logic [sfr_pkg::BYTE_W-1:0] b);
		send_word(1'b0, b, pick_byte());
	endtask

	task automatic send_read(input logic [sfr_pkg::BYTE_W-1:0] idx);
		send_word(1'b1, pick_byte(), idx);
	endtask

	// header, payload of plen bytes, then terminator (or a wrong one)
	task automatic send_frame(input logic [sfr_pkg::BYTE_W-1:0] ftype, input int plen,
			input bit good);
		logic [sfr_pkg::BYTE_W-1:0] tail;
		send_rx(sfr_pkg::SOF_BYTE);
		send_rx(ftype);
		send_rx(sfr_pkg::BYTE_W'(plen));
		repeat (plen) send_rx(pick_byte());
		do tail = pick_byte();
		while (tail == sfr_pkg::EOF_BYTE);
		send_rx(good ? sfr_pkg::EOF_BYTE : tail);
	endtask

	// stop offering and wait until every predicted word is back
	task automatic drain();
		item_valid <= 1'b0;
		while (reply_q.size() != 0) @(posedge clk);
		repeat (SETTLE_PAD) @(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------
	task automatic test_directed();
		// header, 3-byte data next
		send_rx(sfr_pkg::SOF_BYTE); send_rx(8'h05); send_rx(8'h02);
		// looks like data but opens with SOF: taken as a header (type AA, 4 bytes)
		send_rx(sfr_pkg::SOF_BYTE); send_rx(8'hAA); send_rx(sfr_pkg::EOF_BYTE);
		// good, len 4
		send_rx(8'h00); send_rx(8'hFF); send_rx(8'h00); send_rx(sfr_pkg::EOF_BYTE);
		send_rx(8'h10); send_rx(8'h20); send_rx(8'h30);	// no header, no EOF: bad
		// zero length: one-byte chunk
		send_rx(sfr_pkg::SOF_BYTE); send_rx(8'h7F); send_rx(8'h00);
		send_rx(sfr_pkg::EOF_BYTE);	// good, len 1
		send_rx(sfr_pkg::SOF_BYTE); send_rx(8'h80); send_rx(8'h00);
		send_rx(8'hFF);	// bad, len 1
		// good with last type
		send_rx(8'h01); send_rx(sfr_pkg::SOF_BYTE); send_rx(sfr_pkg::EOF_BYTE);
		send_read(8'h00);
		send_read(8'h02);
	endtask

	// largest chunk: length byte FF gives a full-depth chunk of 256 bytes
	task automatic test_full_chunk();
		send_rx(sfr_pkg::SOF_BYTE); send_rx(8'hC3); send_rx(8'hFF);
		repeat (sfr_pkg::CHUNK_DEPTH - 1) send_rx(pick_byte());
		send_rx(sfr_pkg::EOF_BYTE);
	endtask

	task automatic test_buffer_reads();
		send_read(8'hFF);
		send_read(8'h00);
		send_read(8'hAA);
		send_read(8'h55);
		repeat (6) send_read(written_index());
	endtask

	// receiver holds off while bad chunks keep coming, so the input stalls
	task automatic test_backpressure();
		no_gaps      = 1'b1;
		hold_request = 300;
		repeat (8) begin
			send_rx(8'h11); send_rx(pick_byte()); send_rx(8'h44);
		end
		no_gaps = 1'b0;
	endtask

	task automatic test_random();
		int pick;
		while (words_sent < TARGET_WORDS) begin
			pick    = $urandom_range(0, 99);
			no_gaps = ($urandom_range(0, 9) == 0);
			if (pick < 70)
				send_frame(pick_byte(), payload_len(), $urandom_range(0, 9) < 7);
			else if (pick < 85)
				send_read(written_index());
			else
				send_rx(pick_byte());
		end
		no_gaps = 1'b0;
	endtask

	// ------------------------------------------------------------------
	// Result sink: random stalls, plus the long hold-off on request
	// ------------------------------------------------------------------
	initial begin : result_sink
		int stall_left;
		res_ready  = 1'b0;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (hold_request > 0) begin
				stall_left   = hold_request;
				hold_request = 0;
			end
			if (stall_left > 0) begin
				res_ready <= 1'b0;
				stall_left--;
			end else begin
				res_ready <= 1'b1;
				if (!no_gaps && $urandom_range(0, 99) < 25)
					stall_left = idle_len();
			end
		end
	end

	// ------------------------------------------------------------------
	// Result checker: each taken word against the oldest expectation
	// ------------------------------------------------------------------
	initial begin : result_check
		reply_word_t want;
		forever begin
			@(posedge clk);
			if (arst_n && res_valid && res_ready) begin
				if (reply_q.size() == 0) begin
					$error("unexpected result word: kind %0d data %0h", kind, data);
					fail_count++;
				end else begin
					want = reply_q.pop_front();
					if (kind !== want.kind) begin
						$error("kind: expected %0d, got %0d", want.kind, kind);
						fail_count++;
					end
					if (data !== want.data) begin
						$error("data: expected %0h, got %0h", want.data, data);
						fail_count++;
					end
					if (frame_type !== want.ftype) begin
						$error("frame_type: expected %0h, got %0h", want.ftype, frame_type);
						fail_count++;
					end
					if (frame_length !== want.flen) begin
						$error("frame_length: expected %0d, got %0d", want.flen, frame_length);
						fail_count++;
					end
					if (last !== want.last) begin
						$error("last: expected %0b, got %0b", want.last, last);
						fail_count++;
					end
				end
			end
		end
	end

	// watchdog
	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count <= CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("stx_etx_frame_receiver_ack_top verification failed");
		$finish;
	end

	// ------------------------------------------------------------------
	// Sequence of tests
	// ------------------------------------------------------------------
	initial begin
		arst_n         = 1'b0;
		item_valid     = 1'b0;
		action         = 1'b0;
		rx_byte        = '0;
		read_index     = '0;
		no_gaps        = 1'b0;
		hold_request   = 0;
		fail_count     = 0;
		words_sent     = 0;
		chunk_len      = sfr_pkg::HDR_LEN;
		bytes_in_chunk = 0;
		latched_type   = '0;
		foreach (chunk_written[i])
			chunk_written[i] = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		drain();
		test_full_chunk();
		drain();
		test_buffer_reads();
		drain();
		test_backpressure();
		drain();
		test_random();
		drain();

		if (fail_count == 0) begin
			$display("stx_etx_frame_receiver_ack_top verification clean");
		end else begin
			$display("stx_etx_frame_receiver_ack_top verification failed");
		end
		$finish;
	end

endmodule
